@@ design/hetb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the escaped-text to blob decoder.
// Holds the status and escape phase codes, character constants, the result struct
// and the hex digit decoder. It depends on nothing.
package hetb_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNTERM    = 2'd1,
		ST_BAD_ESC   = 2'd2,
		ST_NON_ASCII = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_X    = 2'd1,
		PH_HI   = 2'd2,
		PH_LO   = 2'd3
	} phase_t;

	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_X        = 8'h78;
	localparam logic [7:0] ASCII_MAX   = 8'd127;
	localparam int unsigned LEN_BITS   = 32;

	typedef struct packed {
		logic                byte_valid;
		logic [7:0]          out_byte;
		status_t             status;
		logic                string_done;
		logic [LEN_BITS-1:0] blob_length;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		logic [7:0] d;
		h.ok  = 1'b0;
		h.nib = 4'hF;
		d     = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d     = c - 8'h30;
			h.ok  = 1'b1;
			h.nib = d[3:0];
		end else if (c inside {[8'h41:8'h46]}) begin
			d     = c - 8'h37;
			h.ok  = 1'b1;
			h.nib = d[3:0];
		end else if (c inside {[8'h61:8'h66]}) begin
			d     = c - 8'h57;
			h.ok  = 1'b1;
			h.nib = d[3:0];
		end
		return h;
	endfunction

endpackage

@@ design/hetb_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the escaped-text to blob decoder.
// Depends on hetb_pkg for the status type.
interface hetb_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       is_last;

	modport source (output valid, output char_byte, output is_last, input ready);
	modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

interface hetb_blob_if;
	logic                         valid;
	logic                         ready;
	logic                         byte_valid;
	logic [7:0]                   out_byte;
	hetb_pkg::status_t            status;
	logic                         string_done;
	logic [hetb_pkg::LEN_BITS-1:0] blob_length;

	modport source (output valid, output byte_valid, output out_byte, output status,
		output string_done, output blob_length, input ready);
	modport sink (input valid, input byte_valid, input out_byte, input status,
		input string_done, input blob_length, output ready);
endinterface

@@ design/hex_escaped_text_to_blob.sv @@
`timescale 1ns / 1ps
// Top level of the escaped-text to blob decoder: input register, step logic, result register.
// Depends on hetb_pkg, hetb_if.sv, hetb_step and hetb_out_stage.
//
//   Channel | Direction | Payload
//   text    | in        | char_byte[7:0], is_last
//   blob    | out       | byte_valid, out_byte[7:0], status[1:0], string_done, blob_length[31:0]
//
// One item is accepted per cycle while blob does not stall; its result passes through the input
// register and then the result register before it appears on blob.
// The escape state updates as an item moves from the input register into the result register.
// Reset clears the escape state, the sticky error and the byte count.
// A stall on blob holds the result register and then the input register, and text.ready falls.
module hex_escaped_text_to_blob #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	hetb_char_if.sink   text,
	hetb_blob_if.source blob
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;
	logic              out_ready;
	logic              advance;
	hetb_pkg::result_t result;

	assign advance    = valid_s1 && out_ready;
	assign text.ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1 <= text.char_byte;
			last_s1 <= text.is_last;
		end
	end

	hetb_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.char_byte (char_s1),
		.is_last   (last_s1),
		.result    (result)
	);

	hetb_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_data  (result),
		.load_ready (out_ready),
		.blob       (blob)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		blob.valid && blob.byte_valid |-> blob.status == hetb_pkg::ST_OK)
		else $error("A decoded byte was reported together with an error status.");

	assert property (@(posedge clk) disable iff (!arst_n)
		blob.valid && !blob.byte_valid |-> blob.out_byte == 8'd0)
		else $error("A result without a byte carries a nonzero byte value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("The input register lost an item while the result side stalled.");

endmodule

@@ design/hetb_step.sv @@
`timescale 1ns / 1ps
// Decoder state and the per-character step logic.
// Depends on hetb_pkg; the state advances on each item handed to the result register.
module hetb_step #(
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          char_byte,
	input  logic                is_last,
	output hetb_pkg::result_t   result
);

	hetb_pkg::phase_t        phase_q, phase_n;
	logic [3:0]              high_q, high_n;
	logic                    bad_q, bad_n;
	hetb_pkg::status_t       err_q, err_n;
	logic [COUNT_BITS-1:0]   count_q, count_n;
	logic                    valid;
	logic [7:0]              byte_val;
	hetb_pkg::hex_t          hex;
	logic [hetb_pkg::LEN_BITS-1:0] blen;

	assign hex = hetb_pkg::hex_value(char_byte);

	always_comb begin
		phase_n  = phase_q;
		high_n   = high_q;
		bad_n    = bad_q;
		err_n    = err_q;
		count_n  = count_q;
		valid    = 1'b0;
		byte_val = 8'd0;
		if (err_q == hetb_pkg::ST_OK) begin
			case (phase_q)
				hetb_pkg::PH_IDLE: begin
					if (char_byte == hetb_pkg::CH_BSLASH) begin
						phase_n = hetb_pkg::PH_X;
						bad_n   = 1'b0;
					end else if (char_byte <= hetb_pkg::ASCII_MAX) begin
						valid    = 1'b1;
						byte_val = char_byte;
					end else begin
						err_n = hetb_pkg::ST_NON_ASCII;
					end
				end
				hetb_pkg::PH_X: begin
					if (char_byte != hetb_pkg::CH_X) begin
						bad_n = 1'b1;
					end
					phase_n = hetb_pkg::PH_HI;
				end
				hetb_pkg::PH_HI: begin
					if (!hex.ok) begin
						bad_n = 1'b1;
					end
					high_n  = hex.nib;
					phase_n = hetb_pkg::PH_LO;
				end
				default: begin
					if (!hex.ok || bad_q) begin
						err_n = hetb_pkg::ST_BAD_ESC;
					end else begin
						valid    = 1'b1;
						byte_val = {high_q, hex.nib};
					end
					phase_n = hetb_pkg::PH_IDLE;
					bad_n   = 1'b0;
				end
			endcase
			if (is_last && err_n == hetb_pkg::ST_OK && phase_n != hetb_pkg::PH_IDLE) begin
				err_n = hetb_pkg::ST_UNTERM;
			end
			if (valid && count_q != {COUNT_BITS{1'b1}}) begin
				count_n = count_q + 1'b1;
			end
		end
	end

	generate
		if (COUNT_BITS > hetb_pkg::LEN_BITS) begin : g_wide
			assign blen = (|count_n[COUNT_BITS-1:hetb_pkg::LEN_BITS]) ?
				{hetb_pkg::LEN_BITS{1'b1}} : count_n[hetb_pkg::LEN_BITS-1:0];
		end else begin : g_narrow
			assign blen = hetb_pkg::LEN_BITS'(count_n);
		end
	endgenerate

	always_comb begin
		result.byte_valid  = valid;
		result.out_byte    = byte_val;
		result.status      = err_n;
		result.string_done = is_last;
		result.blob_length = blen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hetb_pkg::PH_IDLE;
			high_q  <= 4'd0;
			bad_q   <= 1'b0;
			err_q   <= hetb_pkg::ST_OK;
			count_q <= '0;
		end else if (advance) begin
			if (is_last) begin
				phase_q <= hetb_pkg::PH_IDLE;
				high_q  <= 4'd0;
				bad_q   <= 1'b0;
				err_q   <= hetb_pkg::ST_OK;
				count_q <= '0;
			end else begin
				phase_q <= phase_n;
				high_q  <= high_n;
				bad_q   <= bad_n;
				err_q   <= err_n;
				count_q <= count_n;
			end
		end
	end

endmodule

@@ design/hetb_out_stage.sv @@
`timescale 1ns / 1ps
// Result register that drives the blob channel.
// Depends on hetb_pkg and hetb_blob_if.
module hetb_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  hetb_pkg::result_t load_data,
	output logic              load_ready,
	hetb_blob_if.source       blob
);

	logic              valid_q;
	hetb_pkg::result_t data_q;

	assign load_ready = !valid_q || blob.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_q <= load_data;
		end
	end

	assign blob.valid       = valid_q;
	assign blob.byte_valid  = data_q.byte_valid;
	assign blob.out_byte    = data_q.out_byte;
	assign blob.status      = data_q.status;
	assign blob.string_done = data_q.string_done;
	assign blob.blob_length = data_q.blob_length;

endmodule
